>>> design/gkg_pkg.sv
// Package for the Geffe keystream generator: register indexes, reset values,
// register degrees and the feedback word and top mask functions.
// Depends on nothing.
package gkg_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [4:0] shamt_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLY_A = 3'd0,
    CFG_POLY_B = 3'd1,
    CFG_POLY_C = 3'd2,
    CFG_SEED_A = 3'd3,
    CFG_SEED_B = 3'd4,
    CFG_SEED_C = 3'd5
  } cfg_idx_t;

  localparam shamt_t DEG_A = 5'd23;
  localparam shamt_t DEG_B = 5'd29;
  localparam shamt_t DEG_C = 5'd31;

  localparam word_t POLY_A_RST = 32'h0040_003B;
  localparam word_t POLY_B_RST = 32'h1000_009D;
  localparam word_t POLY_C_RST = 32'h4000_0040;
  localparam word_t SEED_A_RST = 32'h004E_AAF4;
  localparam word_t SEED_B_RST = 32'h10FE_FB40;
  localparam word_t SEED_C_RST = 32'h4CFB_375E;

  // The shifted polynomial is bit-reversed over the span from bit 0 to its
  // highest set bit.
  function automatic word_t feedback_word(input word_t p, input shamt_t deg);
    word_t  t;
    word_t  rev;
    shamt_t msb;
    t   = p << deg;
    msb = '0;
    for (int i = 0; i < WordW; i++) begin
      if (t[i]) begin
        msb = shamt_t'(i);
      end
    end
    rev = {<<{t}};
    return rev >> (shamt_t'(WordW - 1) - msb);
  endfunction

  function automatic word_t top_mask(input word_t p);
    word_t m;
    m = '0;
    for (int b = 1; b < WordW; b++) begin
      if (p[b]) begin
        m = word_t'(1) << b;
      end
    end
    return m;
  endfunction

endpackage

>>> design/geffe_keystream_generator.sv
// Top level of the Geffe keystream generator: three Galois shift registers,
// their configuration registers and the registered result stage.
// Depends on gkg_pkg.
//
// Usage:
//   The input channel (in_valid, in_ready, in_restart) requests one keystream
//   bit per transfer. With in_restart high the three shift registers are
//   reloaded from their seeds before stepping.
//   The result channel (out_valid, out_ready) carries out_key_bit together
//   with the three register bits of that step.
//   Each result appears in the cycle after its request transfer. Unless
//   the receiver stalls, one request is taken every cycle; the result
//   register is the only stage, so a request is accepted whenever the
//   result register is empty or being emptied. When the receiver stalls,
//   the result is held and in_ready falls until it is taken.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
//   always ready. Feedback words and top masks are derived from the written
//   polynomial in the same transfer. Seeds take effect at the next restart.
//   Writes to indexes beyond the seed of the third register are ignored.
//   Reset loads the documented polynomials and seeds, loads the shift
//   registers from the seeds and empties the result register.
module geffe_keystream_generator
  import gkg_pkg::*;
#(
  parameter shamt_t DegA = DEG_A,
  parameter shamt_t DegB = DEG_B,
  parameter shamt_t DegC = DEG_C
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_key_bit,
  output logic               out_bit_a,
  output logic               out_bit_b,
  output logic               out_bit_c
);

  word_t seed_a_r, seed_b_r, seed_c_r;
  word_t fb_a_r, fb_b_r, fb_c_r;
  word_t tm_a_r, tm_b_r, tm_c_r;
  word_t reg_a_r, reg_b_r, reg_c_r;
  word_t cur_a, cur_b, cur_c;
  word_t reg_a_nxt, reg_b_nxt, reg_c_nxt;
  logic  out_valid_r;
  logic  key_r, bit_a_r, bit_b_r, bit_c_r;
  logic  in_xfer;
  logic  cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    cur_a = in_restart ? seed_a_r : reg_a_r;
    cur_b = in_restart ? seed_b_r : reg_b_r;
    cur_c = in_restart ? seed_c_r : reg_c_r;
    reg_a_nxt = cur_a[0] ? (((cur_a ^ fb_a_r) >> 1) | tm_a_r) : (cur_a >> 1);
    reg_b_nxt = cur_b[0] ? (((cur_b ^ fb_b_r) >> 1) | tm_b_r) : (cur_b >> 1);
    reg_c_nxt = cur_c[0] ? (((cur_c ^ fb_c_r) >> 1) | tm_c_r) : (cur_c >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r <= SEED_A_RST;
      seed_b_r <= SEED_B_RST;
      seed_c_r <= SEED_C_RST;
      fb_a_r   <= feedback_word(POLY_A_RST, DegA);
      fb_b_r   <= feedback_word(POLY_B_RST, DegB);
      fb_c_r   <= feedback_word(POLY_C_RST, DegC);
      tm_a_r   <= top_mask(POLY_A_RST);
      tm_b_r   <= top_mask(POLY_B_RST);
      tm_c_r   <= top_mask(POLY_C_RST);
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_POLY_A: begin
          fb_a_r <= feedback_word(cfg_data, DegA);
          tm_a_r <= top_mask(cfg_data);
        end
        CFG_POLY_B: begin
          fb_b_r <= feedback_word(cfg_data, DegB);
          tm_b_r <= top_mask(cfg_data);
        end
        CFG_POLY_C: begin
          fb_c_r <= feedback_word(cfg_data, DegC);
          tm_c_r <= top_mask(cfg_data);
        end
        CFG_SEED_A: seed_a_r <= cfg_data;
        CFG_SEED_B: seed_b_r <= cfg_data;
        CFG_SEED_C: seed_c_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_a_r     <= SEED_A_RST;
      reg_b_r     <= SEED_B_RST;
      reg_c_r     <= SEED_C_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        reg_a_r     <= reg_a_nxt;
        reg_b_r     <= reg_b_nxt;
        reg_c_r     <= reg_c_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bit_a_r <= cur_a[0];
      bit_b_r <= cur_b[0];
      bit_c_r <= cur_c[0];
      key_r   <= cur_a[0] ? cur_b[0] : cur_c[0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_key_bit = key_r;
  assign out_bit_a   = bit_a_r;
  assign out_bit_b   = bit_b_r;
  assign out_bit_c   = bit_c_r;

`ifndef SYNTHESIS
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted request produced no result");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("empty result register refused a request");

  a_geffe_combine: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (key_r == (bit_a_r ? bit_b_r : bit_c_r)))
    else $error("key bit does not match the combination of register bits");

  a_restart_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_restart && !cfg_xfer) |=> (bit_a_r == $past(seed_a_r[0])))
    else $error("restart did not step from the seed");
`endif

endmodule
